// ===== hw/rtl/iirbq_pkg.sv =====
`timescale 1ns / 1ps

package iirbq_pkg;

	// Fixed word widths of the datapath.
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;
	localparam int DATA_W   = 32;
	localparam int PROD_W   = COEF_W + DATA_W;

	// Storage layout of one section.
	localparam int COEFS_PER_SEC  = 6;
	localparam int DELAYS_PER_SEC = 4;
	localparam int WARMUP_PER_SEC = 4;

	// Coefficient slots within a section.
	localparam logic [2:0] SLOT_B0 = 3'd0;
	localparam logic [2:0] SLOT_B1 = 3'd1;
	localparam logic [2:0] SLOT_B2 = 3'd2;
	localparam logic [2:0] SLOT_A1 = 3'd4;
	localparam logic [2:0] SLOT_A2 = 3'd5;

	// Delay slots within a section.
	localparam logic [1:0] DLY_X1 = 2'd0;
	localparam logic [1:0] DLY_X2 = 2'd1;
	localparam logic [1:0] DLY_Y1 = 2'd2;
	localparam logic [1:0] DLY_Y2 = 2'd3;

	// Sequencer steps within one section.
	localparam int         STEP_W       = 3;
	localparam logic [2:0] STEP_TERM_B0 = 3'd0;
	localparam logic [2:0] STEP_TERM_B1 = 3'd1;
	localparam logic [2:0] STEP_TERM_B2 = 3'd2;
	localparam logic [2:0] STEP_TERM_A1 = 3'd3;
	localparam logic [2:0] STEP_TERM_A2 = 3'd4;
	localparam logic [2:0] STEP_LAST    = 3'd5;
	localparam logic [2:0] STEP_WR_X1   = 3'd2;
	localparam logic [2:0] STEP_WR_X2   = 3'd3;
	localparam logic [2:0] STEP_WR_Y2   = 3'd5;

	// Input kinds carried in tuser.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_COEF   = 1'b1;

	// One term of the section sum.
	typedef enum logic [2:0] {
		TERM_B0,
		TERM_B1,
		TERM_B2,
		TERM_A1,
		TERM_A2
	} term_t;

	// Tag that travels with a term through the multiply-accumulate unit.
	typedef struct packed {
		logic  vld;
		term_t term;
	} mac_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	function automatic term_t step_term(input logic [STEP_W-1:0] step);
		term_t t;
		case (step)
			STEP_TERM_B0: t = TERM_B0;
			STEP_TERM_B1: t = TERM_B1;
			STEP_TERM_B2: t = TERM_B2;
			STEP_TERM_A1: t = TERM_A1;
			default:      t = TERM_A2;
		endcase
		return t;
	endfunction

	function automatic logic [2:0] term_slot(input term_t t);
		logic [2:0] s;
		case (t)
			TERM_B0: s = SLOT_B0;
			TERM_B1: s = SLOT_B1;
			TERM_B2: s = SLOT_B2;
			TERM_A1: s = SLOT_A1;
			default: s = SLOT_A2;
		endcase
		return s;
	endfunction

	function automatic logic [1:0] term_delay(input term_t t);
		logic [1:0] d;
		case (t)
			TERM_B1: d = DLY_X1;
			TERM_B2: d = DLY_X2;
			TERM_A1: d = DLY_Y1;
			default: d = DLY_Y2;
		endcase
		return d;
	endfunction

	// Feedback terms are subtracted from the running sum.
	function automatic logic term_sub(input term_t t);
		return (t == TERM_A1) || (t == TERM_A2);
	endfunction

endpackage

// ===== hw/rtl/iirbq_ram.sv =====
`timescale 1ns / 1ps

module iirbq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rd_data_q;
	logic             rd_vld_q;

	// Storage array with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// One valid bit per entry so that an unwritten entry reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== hw/rtl/iirbq_mac.sv =====
`timescale 1ns / 1ps

module iirbq_mac #(
	parameter int FRAC_BITS = 14
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  iirbq_pkg::mac_ctl_t                   ctl_s1,
	input  logic signed [iirbq_pkg::COEF_W-1:0]   coef,
	input  logic signed [iirbq_pkg::DATA_W-1:0]   data,
	output iirbq_pkg::mac_ctl_t                   ctl_s2,
	output logic signed [iirbq_pkg::DATA_W-1:0]   acc,
	output logic signed [iirbq_pkg::DATA_W-1:0]   acc_next
);

	import iirbq_pkg::*;

	localparam int PW    = PROD_W - FRAC_BITS;
	localparam int ACC_W = (PW > DATA_W) ? PW : DATA_W;
	localparam int SUM_W = ACC_W + 1;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'sh7fff_ffff);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'($signed(32'h8000_0000));

	logic signed [PROD_W-1:0] mul_w;
	logic signed [PW-1:0]     prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_d;
	logic signed [SUM_W-1:0]  sum_w;
	logic signed [SUM_W-1:0]  addend_w;

	// Multiply and scale down; the arithmetic shift rounds toward minus infinity.
	assign mul_w = coef * data;

	always_ff @(posedge clk) begin
		prod_s2 <= PW'(mul_w >>> FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	// The first term loads the sum; the others add or subtract and saturate to 32 bits.
	always_comb begin
		addend_w = SUM_W'(prod_s2);
		if (term_sub(ctl_s2.term)) begin
			sum_w = SUM_W'(acc_q) - addend_w;
		end else begin
			sum_w = SUM_W'(acc_q) + addend_w;
		end
		if (ctl_s2.term == TERM_B0) begin
			acc_d = ACC_W'(prod_s2);
		end else if (sum_w > SAT_HI) begin
			acc_d = ACC_W'(SAT_HI);
		end else if (sum_w < SAT_LO) begin
			acc_d = ACC_W'(SAT_LO);
		end else begin
			acc_d = ACC_W'(sum_w);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.vld) begin
			acc_q <= acc_d;
		end
	end

	assign acc      = DATA_W'(acc_q);
	assign acc_next = DATA_W'(acc_d);

endmodule

// ===== hw/rtl/iir_biquad_cascade_filter_core.sv =====
`timescale 1ns / 1ps
// A sample transaction is accepted only in idle, and the next one only after its result has been
// loaded into the output register; the shared multiply-accumulate unit takes five terms per section,
// plus an idle step before a section's sum feeds the next section. Coefficient writes are taken in idle.
// Reset clears the stored coefficients and delays (through per-entry valid bits), the warm-up
// count and the output valid flag; sections reset to 1.

module iir_biquad_cascade_filter_core #(
	parameter int MAX_SECTIONS   = 8,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // sample_in, section_sel, coef_sel, coef_value, zero pad
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // sample_out
	output logic        m_tuser    // settled
);

	import iirbq_pkg::*;

	localparam int SEC_W   = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int CNT_W   = $clog2(MAX_SECTIONS + 1);
	localparam int WU_W    = $clog2(WARMUP_PER_SEC * MAX_SECTIONS + 1);
	localparam int C_DEPTH = MAX_SECTIONS * COEFS_PER_SEC;
	localparam int D_DEPTH = MAX_SECTIONS * DELAYS_PER_SEC;
	localparam int CADDR_W = $clog2(C_DEPTH);
	localparam int DADDR_W = $clog2(D_DEPTH);
	localparam int CSUM_W  = SEC_W + 3;

	// Input fields.
	logic                       in_op;
	logic signed [SAMPLE_W-1:0] in_sample;
	logic [2:0]                 in_sec;
	logic [2:0]                 in_slot;
	logic [COEF_W-1:0]          in_coef;

	assign in_op     = s_tuser;
	assign in_sample = $signed(s_tdata[15:0]);
	assign in_sec    = s_tdata[18:16];
	assign in_slot   = s_tdata[21:19];
	assign in_coef   = s_tdata[37:22];

	state_t                     state_q;
	state_t                     state_d;
	logic [STEP_W-1:0]          step_q;
	logic [SEC_W-1:0]           sec_q;
	logic [SEC_W-1:0]           d2_sec_q;
	logic [3:0]                 num_sec_q;
	logic [CNT_W-1:0]           n_eff;
	logic                       last_sec;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [DATA_W-1:0]   xin_q;
	logic signed [DATA_W-1:0]   d0old_q;
	logic signed [DATA_W-1:0]   d2old_q;
	logic [WU_W-1:0]            warm_q;
	logic [WU_W-1:0]            limit_w;
	logic                       settled_w;
	logic                       m_tvalid_q;
	logic [15:0]                out_sample_q;
	logic                       out_settled_q;
	logic signed [15:0]         sat16_w;
	logic                       out_load;

	mac_ctl_t                   rd_ctl;
	mac_ctl_t                   ctl_s1;
	mac_ctl_t                   mac_st;
	logic                       first_s1;

	logic                       coef_wr_en;
	logic [CADDR_W-1:0]         coef_wr_addr;
	logic [CADDR_W-1:0]         coef_rd_addr;
	logic [COEF_W-1:0]          coef_rd;

	logic                       dly_wr_en;
	logic [DADDR_W-1:0]         dly_wr_addr;
	logic [DATA_W-1:0]          dly_wr_data;
	logic [DADDR_W-1:0]         dly_rd_addr;
	logic [DATA_W-1:0]          dly_rd;

	logic signed [DATA_W-1:0]   mac_acc;
	logic signed [DATA_W-1:0]   mac_acc_next;
	logic signed [DATA_W-1:0]   x_cur;
	logic signed [DATA_W-1:0]   mac_data;

	// Sections in use: zero counts as one, large values clamp to the maximum.
	always_comb begin
		if (num_sec_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (int'(num_sec_q) > MAX_SECTIONS) begin
			n_eff = CNT_W'(MAX_SECTIONS);
		end else begin
			n_eff = CNT_W'(num_sec_q);
		end
	end

	assign last_sec  = (int'(sec_q) + 1) == int'(n_eff);
	assign limit_w   = WU_W'(int'(n_eff) * WARMUP_PER_SEC);
	assign settled_w = warm_q >= limit_w;
	assign out_load  = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && (in_op == OP_SAMPLE)) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if ((step_q == STEP_LAST) && last_sec) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs: handshake, memory reads and coefficient writes.
	always_comb begin
		s_tready    = 1'b0;
		rd_ctl.vld  = 1'b0;
		rd_ctl.term = TERM_B0;
		coef_wr_en  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				coef_wr_en = s_tvalid && (in_op == OP_COEF) &&
					(int'(in_sec) < MAX_SECTIONS) && (int'(in_slot) < COEFS_PER_SEC);
			end
			ST_RUN: begin
				if (step_q <= STEP_TERM_A2) begin
					rd_ctl.vld  = 1'b1;
					rd_ctl.term = step_term(step_q);
				end
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign coef_wr_addr = CADDR_W'(CSUM_W'(SEC_W'(in_sec)) * CSUM_W'(COEFS_PER_SEC) +
		CSUM_W'(in_slot));
	assign coef_rd_addr = CADDR_W'(CSUM_W'(sec_q) * CSUM_W'(COEFS_PER_SEC) +
		CSUM_W'(term_slot(rd_ctl.term)));
	assign dly_rd_addr  = DADDR_W'({sec_q, term_delay(rd_ctl.term)});

	// Delay write-back: the new output y1 as soon as the sum completes, the shifted
	// taps on fixed steps after their old values have been read.
	always_comb begin
		dly_wr_en   = 1'b0;
		dly_wr_addr = '0;
		dly_wr_data = '0;
		if (mac_st.vld && (mac_st.term == TERM_A2)) begin
			dly_wr_en   = 1'b1;
			dly_wr_addr = DADDR_W'({d2_sec_q, DLY_Y1});
			dly_wr_data = mac_acc_next;
		end else if (state_q == ST_RUN) begin
			case (step_q)
				STEP_WR_X1: begin
					dly_wr_en   = 1'b1;
					dly_wr_addr = DADDR_W'({sec_q, DLY_X1});
					dly_wr_data = xin_q;
				end
				STEP_WR_X2: begin
					dly_wr_en   = 1'b1;
					dly_wr_addr = DADDR_W'({sec_q, DLY_X2});
					dly_wr_data = d0old_q;
				end
				STEP_WR_Y2: begin
					dly_wr_en   = 1'b1;
					dly_wr_addr = DADDR_W'({sec_q, DLY_Y2});
					dly_wr_data = d2old_q;
				end
				default: begin
					dly_wr_en = 1'b0;
				end
			endcase
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			sec_q      <= '0;
			num_sec_q  <= 4'd1;
			warm_q     <= '0;
			m_tvalid_q <= 1'b0;
			ctl_s1     <= '0;
		end else begin
			state_q <= state_d;
			ctl_s1  <= rd_ctl;
			if (cfg_we) begin
				num_sec_q <= cfg_wdata;
			end
			if (state_q == ST_IDLE) begin
				step_q <= '0;
				sec_q  <= '0;
			end else if (state_q == ST_RUN) begin
				if (step_q == STEP_LAST) begin
					step_q <= '0;
					if (!last_sec) begin
						sec_q <= sec_q + SEC_W'(1);
					end
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				if (!settled_w) begin
					warm_q <= warm_q + WU_W'(1);
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Operand for the feed-forward term: the sample for the first section,
	// the previous section's sum otherwise.
	assign x_cur    = first_s1 ? DATA_W'(sample_q) : mac_acc;
	assign mac_data = (ctl_s1.term == TERM_B0) ? x_cur : $signed(dly_rd);

	// Datapath registers.
	always_ff @(posedge clk) begin
		first_s1 <= (sec_q == '0);
		if ((state_q == ST_IDLE) && s_tvalid) begin
			sample_q <= in_sample;
		end
		if ((state_q == ST_RUN) && (step_q == STEP_LAST)) begin
			d2_sec_q <= sec_q;
		end
		if (ctl_s1.vld) begin
			case (ctl_s1.term)
				TERM_B0: xin_q   <= x_cur;
				TERM_B1: d0old_q <= $signed(dly_rd);
				TERM_A1: d2old_q <= $signed(dly_rd);
				default: begin
				end
			endcase
		end
	end

	// Output saturation to 16 bits and the output register.
	always_comb begin
		if (mac_acc > 32'sd32767) begin
			sat16_w = 16'sh7fff;
		end else if (mac_acc < -32'sd32768) begin
			sat16_w = $signed(16'h8000);
		end else begin
			sat16_w = 16'(mac_acc);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sample_q  <= sat16_w;
			out_settled_q <= settled_w;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_sample_q;
	assign m_tuser  = out_settled_q;

	iirbq_ram #(
		.WIDTH(COEF_W),
		.DEPTH(C_DEPTH)
	) u_coef_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (coef_wr_en),
		.wr_addr(coef_wr_addr),
		.wr_data(in_coef),
		.rd_addr(coef_rd_addr),
		.rd_data(coef_rd)
	);

	iirbq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(D_DEPTH)
	) u_delay_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (dly_wr_en),
		.wr_addr(dly_wr_addr),
		.wr_data(dly_wr_data),
		.rd_addr(dly_rd_addr),
		.rd_data(dly_rd)
	);

	iirbq_mac #(
		.FRAC_BITS(COEF_FRAC_BITS)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s1  (ctl_s1),
		.coef    ($signed(coef_rd)),
		.data    (mac_data),
		.ctl_s2  (mac_st),
		.acc     (mac_acc),
		.acc_next(mac_acc_next)
	);

endmodule
